// ----- sv/ncs_pkg.sv -----
package ncs_pkg;

  localparam int unsigned PAGE_NUM_W = 24;
  localparam int unsigned ADDR_CNT_W = 3;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_CMD1  = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_CMD2  = 7'b0001000,
    PH_WAIT  = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_DESEL = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_PROG  = 2'd1,
    OP_ERASE = 2'd2,
    OP_ID    = 2'd3
  } op_t;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic [3:0] CT_IDLE     = 4'd0;
  localparam logic [3:0] CT_SELECT   = 4'd1;
  localparam logic [3:0] CT_COMMAND  = 4'd2;
  localparam logic [3:0] CT_ADDRESS  = 4'd3;
  localparam logic [3:0] CT_WRITE    = 4'd4;
  localparam logic [3:0] CT_READ     = 4'd5;
  localparam logic [3:0] CT_WAIT     = 4'd6;
  localparam logic [3:0] CT_DESELECT = 4'd7;
  localparam logic [3:0] CT_REJECT   = 4'd8;

  localparam logic [7:0] CMD_READ1  = 8'h00;
  localparam logic [7:0] CMD_READ2  = 8'h30;
  localparam logic [7:0] CMD_PROG1  = 8'h80;
  localparam logic [7:0] CMD_PROG2  = 8'h10;
  localparam logic [7:0] CMD_ERASE1 = 8'h60;
  localparam logic [7:0] CMD_ERASE2 = 8'hD0;
  localparam logic [7:0] CMD_ID     = 8'h90;

  localparam logic [31:0] ID_BYTES = 32'd5;

  typedef struct packed {
    logic        kind;
    op_t         operation;
    logic [31:0] address;
    logic [31:0] length;
    logic        flash_ready;
    logic [7:0]  flash_byte;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [3:0]  cycle_type;
    logic [7:0]  bus_byte;
    logic [31:0] byte_index;
    logic        active;
    logic        last;
  } res_t;

  function automatic logic [7:0] first_cmd(input op_t op);
    logic [7:0] c;
    case (op)
      OP_READ:  c = CMD_READ1;
      OP_PROG:  c = CMD_PROG1;
      OP_ERASE: c = CMD_ERASE1;
      default:  c = CMD_ID;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] second_cmd(input op_t op);
    logic [7:0] c;
    case (op)
      OP_READ:  c = CMD_READ2;
      OP_PROG:  c = CMD_PROG2;
      OP_ERASE: c = CMD_ERASE2;
      default:  c = CMD_READ1;
    endcase
    return c;
  endfunction

  function automatic logic [ADDR_CNT_W-1:0] addr_bytes(input op_t op);
    logic [ADDR_CNT_W-1:0] n;
    case (op)
      OP_READ:  n = 3'd5;
      OP_PROG:  n = 3'd5;
      OP_ERASE: n = 3'd3;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// ----- sv/ncs_seq.sv -----
module ncs_seq #(
  parameter int unsigned PAGE_BYTES  = 2048,
  parameter int unsigned BLOCK_BYTES = 131072
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  ncs_pkg::req_t req,
  output ncs_pkg::res_t res
);
  import ncs_pkg::*;

  localparam int unsigned PG_LSB  = $clog2(PAGE_BYTES);
  localparam int unsigned BLK_LSB = $clog2(BLOCK_BYTES);
  localparam int unsigned COL_W   = PG_LSB;
  localparam logic [31:0] BLOCK_INC = 32'(BLOCK_BYTES);

  phase_t                  phase_r, phase_nxt;
  op_t                     op_r, op_nxt;
  logic [PAGE_NUM_W-1:0]   page_r, page_nxt;
  logic [COL_W-1:0]        column_r, column_nxt;
  logic [31:0]             done_r, done_nxt;
  logic [31:0]             left_r, left_nxt;
  logic [31:0]             erase_r, erase_nxt;
  logic [ADDR_CNT_W-1:0]   acnt_r, acnt_nxt;

  logic [15:0]             col_ext;
  logic [31:0]             ea_inc;
  logic [31:0]             left_dec;
  logic [7:0]              abyte;

  assign col_ext  = 16'(column_r);
  assign ea_inc   = erase_r + BLOCK_INC;
  assign left_dec = left_r - 32'd1;

  always_comb begin
    abyte = 8'h00;
    if (op_r == OP_ERASE) begin
      case (acnt_r)
        3'd0:    abyte = page_r[7:0];
        3'd1:    abyte = page_r[15:8];
        3'd2:    abyte = page_r[23:16];
        default: abyte = 8'h00;
      endcase
    end else if (op_r != OP_ID) begin
      case (acnt_r)
        3'd0:    abyte = col_ext[7:0];
        3'd1:    abyte = col_ext[15:8];
        3'd2:    abyte = page_r[7:0];
        3'd3:    abyte = page_r[15:8];
        3'd4:    abyte = page_r[23:16];
        default: abyte = 8'h00;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    page_nxt   = page_r;
    column_nxt = column_r;
    done_nxt   = done_r;
    left_nxt   = left_r;
    erase_nxt  = erase_r;
    acnt_nxt   = acnt_r;
    res        = '0;

    if (req.kind == KIND_START) begin
      if (phase_r != PH_IDLE) begin
        res.active = 1'b1;
      end else if (req.operation == OP_ERASE &&
                   (req.address[BLK_LSB-1:0] != '0 || req.length[BLK_LSB-1:0] != '0)) begin
        res.cycle_type = CT_REJECT;
        res.last       = 1'b1;
      end else begin
        op_nxt     = req.operation;
        done_nxt   = '0;
        acnt_nxt   = '0;
        erase_nxt  = (req.operation == OP_ERASE) ? req.address : '0;
        page_nxt   = (req.operation == OP_ID) ? '0 : PAGE_NUM_W'(req.address >> PG_LSB);
        column_nxt = (req.operation == OP_READ || req.operation == OP_PROG) ?
                     req.address[COL_W-1:0] : '0;
        left_nxt   = (req.operation == OP_ID) ? ID_BYTES : req.length;
        phase_nxt  = (left_nxt != '0) ? PH_CMD1 : PH_DESEL;
        res.cycle_type = CT_SELECT;
        res.active     = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_CMD1: begin
          res.cycle_type = CT_COMMAND;
          res.active     = 1'b1;
          res.bus_byte   = first_cmd(op_r);
          acnt_nxt       = '0;
          phase_nxt      = PH_ADDR;
        end
        PH_ADDR: begin
          res.cycle_type = CT_ADDRESS;
          res.active     = 1'b1;
          res.bus_byte   = abyte;
          acnt_nxt       = acnt_r + 3'd1;
          if (acnt_nxt >= addr_bytes(op_r)) begin
            acnt_nxt  = '0;
            phase_nxt = (op_r == OP_PROG || op_r == OP_ID) ? PH_DATA : PH_CMD2;
          end
        end
        PH_CMD2: begin
          res.cycle_type = CT_COMMAND;
          res.active     = 1'b1;
          res.bus_byte   = second_cmd(op_r);
          phase_nxt      = PH_WAIT;
        end
        PH_WAIT: begin
          res.cycle_type = CT_WAIT;
          res.active     = 1'b1;
          if (req.flash_ready) begin
            if (op_r == OP_READ) begin
              phase_nxt = PH_DATA;
            end else if (op_r == OP_PROG) begin
              column_nxt = '0;
              page_nxt   = page_r + 24'd1;
              phase_nxt  = (left_r != '0) ? PH_CMD1 : PH_DESEL;
            end else begin
              erase_nxt = ea_inc;
              left_nxt  = left_r - BLOCK_INC;
              page_nxt  = PAGE_NUM_W'(ea_inc >> PG_LSB);
              phase_nxt = (left_nxt != '0) ? PH_CMD1 : PH_DESEL;
            end
          end
        end
        PH_DATA: begin
          res.active     = 1'b1;
          res.cycle_type = (op_r == OP_PROG) ? CT_WRITE : CT_READ;
          res.bus_byte   = (op_r == OP_PROG) ? req.write_byte : req.flash_byte;
          res.byte_index = done_r;
          done_nxt       = done_r + 32'd1;
          left_nxt       = left_dec;
          if (op_r == OP_ID) begin
            if (left_dec == '0) begin
              phase_nxt = PH_DESEL;
            end
          end else begin
            column_nxt = column_r + COL_W'(1);
            if (column_r == '1 || left_dec == '0) begin
              if (op_r == OP_PROG) begin
                phase_nxt = PH_CMD2;
              end else begin
                column_nxt = '0;
                page_nxt   = page_r + 24'd1;
                phase_nxt  = (left_dec != '0) ? PH_CMD1 : PH_DESEL;
              end
            end
          end
        end
        PH_DESEL: begin
          res.cycle_type = CT_DESELECT;
          res.active     = 1'b1;
          res.last       = 1'b1;
          phase_nxt      = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      op_r     <= OP_READ;
      page_r   <= '0;
      column_r <= '0;
      done_r   <= '0;
      left_r   <= '0;
      erase_r  <= '0;
      acnt_r   <= '0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      op_r     <= op_nxt;
      page_r   <= page_nxt;
      column_r <= column_nxt;
      done_r   <= done_nxt;
      left_r   <= left_nxt;
      erase_r  <= erase_nxt;
      acnt_r   <= acnt_nxt;
    end
  end

endmodule

// ----- sv/nand_flash_command_sequencer_core.sv -----
// Large-page NAND bus-cycle sequencer. A start request (in_kind 0) opens a read, program,
// block erase or read id operation and yields the chip-select cycle (an active idle result
// while busy); each step request (in_kind 1) yields exactly one bus cycle: command, address,
// data, busy wait or deselect (idle when no operation is open). Reads and programs resend
// command and address at each page boundary; erase needs a block-aligned address and
// length, else the start yields a reject. PAGE_BYTES and BLOCK_BYTES must be powers of two.
// One request is taken per clock while in_stall is low; it passes the input register, then
// the result register, the sequencer state updating as it moves into the result register.
// in_stall rises only when both registers are full and the result is held by out_stall.
module nand_flash_command_sequencer_core #(
  parameter int unsigned PAGE_BYTES  = 2048,
  parameter int unsigned BLOCK_BYTES = 131072
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_address,
  input  logic [31:0] in_length,
  input  logic        in_flash_ready,
  input  logic [7:0]  in_flash_byte,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_cycle_type,
  output logic [7:0]  out_bus_byte,
  output logic [31:0] out_byte_index,
  output logic        out_active,
  output logic        out_last
);
  import ncs_pkg::*;

  logic  s1_valid_r;
  req_t  s1_req_r;
  logic  out_valid_r;
  res_t  out_res_r;
  res_t  seq_res;
  logic  adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  ncs_seq #(
    .PAGE_BYTES  (PAGE_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_valid_r && adv),
    .req   (s1_req_r),
    .res   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r.kind        <= in_kind;
      s1_req_r.operation   <= op_t'(in_operation);
      s1_req_r.address     <= in_address;
      s1_req_r.length      <= in_length;
      s1_req_r.flash_ready <= in_flash_ready;
      s1_req_r.flash_byte  <= in_flash_byte;
      s1_req_r.write_byte  <= in_write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cycle_type = out_res_r.cycle_type;
  assign out_bus_byte   = out_res_r.bus_byte;
  assign out_byte_index = out_res_r.byte_index;
  assign out_active     = out_res_r.active;
  assign out_last       = out_res_r.last;

endmodule

// ----- sv/ncs_checker.sv -----
module ncs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_cycle_type,
  input logic [7:0]  out_bus_byte,
  input logic [31:0] out_byte_index,
  input logic        out_active,
  input logic        out_last
);
  import ncs_pkg::*;

  a_last_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      (out_cycle_type == CT_DESELECT || out_cycle_type == CT_REJECT))
    else $error("last on a cycle that is neither deselect nor rejected");

  a_reject_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_type == CT_REJECT |-> !out_active)
    else $error("rejected cycle reports active");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_type != CT_WRITE && out_cycle_type != CT_READ |->
      out_byte_index == 32'd0)
    else $error("byte index set on a non-data cycle");

  a_bus_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cycle_type == CT_IDLE || out_cycle_type == CT_SELECT ||
                  out_cycle_type == CT_WAIT || out_cycle_type == CT_DESELECT) |->
      out_bus_byte == 8'h00)
    else $error("bus byte set on a cycle that moves no byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cycle_type) &&
      $stable(out_bus_byte) && $stable(out_byte_index) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind nand_flash_command_sequencer_core ncs_checker u_ncs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_cycle_type (out_cycle_type),
  .out_bus_byte   (out_bus_byte),
  .out_byte_index (out_byte_index),
  .out_active     (out_active),
  .out_last       (out_last)
);
